### rtl/slm_pkg.sv
package slm_pkg;

  localparam int LEN_W  = 5;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic load;
    logic cfg_wr;
    logic prime;
    logic step;
  } slm_cmd_t;

  typedef struct packed {
    logic load_final;
    logic merge_final;
  } slm_sts_t;

endpackage

### rtl/slm_ctrl.sv
module slm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             cfg_valid,
  input  slm_pkg::slm_sts_t sts,
  output logic             busy,
  output logic             cfg_ready,
  output slm_pkg::slm_cmd_t cmd
);
  import slm_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PRIME,
    S_MERGE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // config write never lands on the same edge as a load request
  assign cfg_ready  = !busy_r && !start;
  assign busy       = busy_r;
  assign cmd.load   = start && !busy_r;
  assign cmd.cfg_wr = cfg_valid && cfg_ready;
  assign cmd.prime  = (state_r == S_PRIME);
  assign cmd.step   = (state_r == S_MERGE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (cmd.load && sts.load_final) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (sts.merge_final) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_LOAD);
    end
  end

endmodule

### rtl/slm_datapath.sv
module slm_datapath #(
  parameter int MAX_LEN = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slm_pkg::slm_cmd_t                  cmd,
  input  logic        [slm_pkg::LEN_W-1:0]   cfg_data,
  input  logic signed [slm_pkg::DATA_W-1:0]  in_value,
  output slm_pkg::slm_sts_t                  sts,
  output logic                               out_valid,
  output logic signed [slm_pkg::DATA_W-1:0]  out_merged_value,
  output logic                               out_last
);
  import slm_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TOT_W = $clog2(2 * MAX_LEN + 1);

  logic        [DATA_W-1:0] mem_a [MAX_LEN];
  logic        [DATA_W-1:0] mem_b [MAX_LEN];

  logic        [LEN_W-1:0]  list_length_r;
  logic        [TOT_W-1:0]  load_count_r, load_count_nxt;
  logic        [TOT_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic                     out_valid_r, out_last_r;
  logic signed [DATA_W-1:0] out_value_r;

  logic [LEN_W:0]   len_clamp;
  logic [TOT_W-1:0] eff_len, total, b_waddr;
  logic             a_ok, b_ok, take_a;

  // effective length: zero acts as one, clamp at the array depth
  always_comb begin
    len_clamp = {1'b0, list_length_r};
    if (list_length_r == '0) begin
      len_clamp = (LEN_W+1)'(1);
    end else if (len_clamp > (LEN_W+1)'(MAX_LEN)) begin
      len_clamp = (LEN_W+1)'(MAX_LEN);
    end
  end

  assign eff_len = TOT_W'(len_clamp);
  assign total   = TOT_W'({len_clamp, 1'b0});
  assign b_waddr = load_count_r - eff_len;

  assign sts.load_final  = (TOT_W'(load_count_r + 1'b1) == total);
  assign sts.merge_final = (TOT_W'(i_r + j_r + 1'b1) == total);

  assign a_ok   = (i_r < eff_len);
  assign b_ok   = (j_r < eff_len);
  // ties go to the second list
  assign take_a = a_ok && (!b_ok || (rd_a_r < rd_b_r));

  always_comb begin
    load_count_nxt = load_count_r;
    if (cmd.cfg_wr) begin
      load_count_nxt = '0;
    end else if (cmd.load) begin
      load_count_nxt = sts.load_final ? '0 : TOT_W'(load_count_r + 1'b1);
    end
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.prime) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.step) begin
      if (take_a) begin
        i_nxt = TOT_W'(i_r + 1'b1);
      end else begin
        j_nxt = TOT_W'(j_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_length_r <= LEN_W'(1);
      load_count_r  <= '0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        list_length_r <= cfg_data;
      end
      load_count_r <= load_count_nxt;
      out_valid_r  <= cmd.step;
      out_last_r   <= cmd.step && sts.merge_final;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (cmd.step) begin
      out_value_r <= take_a ? rd_a_r : rd_b_r;
    end
  end

  // list storage, one write port, registered read at the next head index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (load_count_r < eff_len) begin
        mem_a[load_count_r[IDX_W-1:0]] <= in_value;
      end else begin
        mem_b[b_waddr[IDX_W-1:0]] <= in_value;
      end
    end
    rd_a_r <= mem_a[i_nxt[IDX_W-1:0]];
    rd_b_r <= mem_b[j_nxt[IDX_W-1:0]];
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

### rtl/sorted_list_merge.sv
// channel  | ports                                         | direction
// ---------+-----------------------------------------------+----------
// input    | start, busy, in_value                         | in
// result   | out_valid, out_merged_value, out_last         | out
// config   | cfg_valid, cfg_ready, cfg_data                | in
//
// a load request is taken while busy is low; the request that completes
// both lists starts the merge: a priming state for the list memory read,
// then one result per cycle for all 2*length results, busy high until the
// final result
// synchronous active-low reset returns to loading with length one
// results are strobed for one cycle and cannot be held off
module sorted_list_merge #(
  parameter int MAX_LEN = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [slm_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [slm_pkg::DATA_W-1:0]  out_merged_value,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [slm_pkg::LEN_W-1:0]   cfg_data
);
  import slm_pkg::*;

  slm_cmd_t cmd;
  slm_sts_t sts;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  slm_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_data         (cfg_data),
    .in_value         (in_value),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_last         (out_last)
  );

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last marker without result strobe");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe outside merge");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> !busy)
    else $error("busy still high after final result");

  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("config accepted during merge");

endmodule

### test/sorted_list_merge_test.sv
`timescale 1ns / 100ps

module sorted_list_merge_test;
  import slm_pkg::*;

  localparam int MAX_LEN     = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } merged_entry_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_merged_value;
  logic                     out_last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [LEN_W-1:0]         cfg_data;

  // predictor state
  logic signed [DATA_W-1:0] first_vals [MAX_LEN];
  logic signed [DATA_W-1:0] second_vals [MAX_LEN];
  int                       loaded;
  logic [LEN_W-1:0]         list_len;
  merged_entry_t            merged_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 16;

  sorted_list_merge #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_merged_value(out_merged_value),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int eff_len(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_LEN) return MAX_LEN;
    return int'(len);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // stores one loaded value; the request that completes both lists yields the merge
  task automatic predict_load(input logic signed [DATA_W-1:0] v);
    int            n;
    int            a;
    int            b;
    merged_entry_t e;
    n = eff_len(list_len);
    if (loaded < n) first_vals[loaded] = v;
    else second_vals[loaded - n] = v;
    loaded++;
    if (loaded == 2 * n) begin
      loaded = 0;
      a = 0;
      b = 0;
      for (int k = 0; k < 2 * n; k++) begin
        // ties go to the second list
        if (b >= n || (a < n && first_vals[a] < second_vals[b])) begin
          e.value = first_vals[a];
          a++;
        end else begin
          e.value = second_vals[b];
          b++;
        end
        e.last = (k == 2 * n - 1);
        merged_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    merged_entry_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (merged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d last %b", out_merged_value, out_last));
      end else begin
        want = merged_q.pop_front();
        if (out_merged_value !== want.value)
          report_mismatch($sformatf("merged_value %0d, want %0d", out_merged_value, want.value));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
      end
    end
  end

  task automatic send_value(input logic signed [DATA_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_load(v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off requests until every merged value is out
  task automatic drain();
    start <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    list_len = len;
    loaded   = 0;
  endtask

  task automatic send_lists(input logic signed [DATA_W-1:0] l0 [MAX_LEN],
                            input logic signed [DATA_W-1:0] l1 [MAX_LEN]);
    int n;
    n = eff_len(list_len);
    for (int i = 0; i < n; i++) send_value(l0[i]);
    for (int i = 0; i < n; i++) send_value(l1[i]);
  endtask

  task automatic run_batch();
    int                       n;
    int                       mode;
    int                       j;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] lists [2][MAX_LEN];
    n = eff_len(list_len);
    mode = $urandom_range(0, 9);
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        if (mode < 3) lists[l][i] = $urandom_range(0, 8) - 4;
        else lists[l][i] = $urandom;
      end
      // mostly sorted lists, sometimes unsorted
      if (mode != 9) begin
        for (int i = 1; i < n; i++) begin
          t = lists[l][i];
          j = i;
          while (j > 0 && lists[l][j - 1] > t) begin
            lists[l][j] = lists[l][j - 1];
            j--;
          end
          lists[l][j] = t;
        end
      end
    end
    send_lists(lists[0], lists[1]);
  endtask

  task automatic send_partial();
    int n;
    n = eff_len(list_len);
    repeat ($urandom_range(1, 2 * n - 1)) send_value($urandom);
  endtask

  task automatic test_default_length();
    send_value(5);
    send_value(3);
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
  endtask

  task automatic test_length_zero();
    write_length(0);
    send_value(-1);
    send_value(0);
    send_value(7);
    send_value(7);
  endtask

  task automatic test_partial_load_dropped();
    write_length(3);
    send_value(100);
    send_value(200);
    write_length(2);
    send_value(1);
    send_value(4);
    send_value(2);
    send_value(3);
  endtask

  task automatic test_signed_extremes();
    logic signed [DATA_W-1:0] l0 [MAX_LEN];
    logic signed [DATA_W-1:0] l1 [MAX_LEN];
    write_length(4);
    l0[0] = VAL_MIN; l0[1] = -1; l0[2] = 0; l0[3] = VAL_MAX;
    l1[0] = VAL_MIN; l1[1] = 0;  l1[2] = 1; l1[3] = VAL_MAX;
    send_lists(l0, l1);
  endtask

  task automatic test_random_merges(input int idle_pct, input logic [LEN_W-1:0] big_len);
    send_idle_pct = idle_pct;
    write_length(big_len);
    run_batch();
    if ($urandom_range(0, 3) == 0) send_partial();
    write_length(LEN_W'($urandom_range(1, 6)));
    run_batch();
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_value  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    list_len  = 1;
    loaded    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_length();
    test_length_zero();
    test_partial_load_dropped();
    test_signed_extremes();
    test_random_merges(16, 16);
    test_random_merges(80, 31);
    test_random_merges(0, 9);

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && merged_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/slm_pkg.sv
rtl/slm_ctrl.sv
rtl/slm_datapath.sv
rtl/sorted_list_merge.sv
test/sorted_list_merge_test.sv
